// File: sv/plane_constrained_translation_top_defines.svh
// Assertion macros for the plane-constrained translation block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PLANE_CONSTRAINED_TRANSLATION_TOP_DEFINES_SVH
`define PLANE_CONSTRAINED_TRANSLATION_TOP_DEFINES_SVH

// Implication check sampled on the rising clock, off during reset.
`define PCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define PCT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: sv/pct_pkg.sv
// Shared types, register codes and saturation helper for the
// plane-constrained translation block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

   localparam int DIV_STEPS = 34;            // quotient bits, q < 2^34
   localparam int DIV_LAT   = DIV_STEPS + 1; // steps plus rounding stage
   localparam int FRONT_LAT = 6;
   localparam int BACK_LAT  = 3;
   localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

   typedef enum logic [2:0] {
      REG_CLAMP_ENABLE = 3'd0,
      REG_BOUND_A_X    = 3'd1,
      REG_BOUND_A_Y    = 3'd2,
      REG_BOUND_A_Z    = 3'd3,
      REG_BOUND_B_X    = 3'd4,
      REG_BOUND_B_Y    = 3'd5,
      REG_BOUND_B_Z    = 3'd6
   } reg_idx_type;

   typedef logic [2:0][31:0] vec3_type;

   // per-item context carried alongside the arithmetic
   typedef struct packed {
      logic       zero;
      logic       dneg;
      logic [2:0] nneg;
      vec3_type   start;
      vec3_type   delta;
   } ctx_type;

   typedef struct packed {
      ctx_type          ctx;
      logic [2:0][95:0] num;
      logic [63:0]      den;
   } front_type;

   typedef struct packed {
      logic     clamp_enable;
      vec3_type bound_a;
      vec3_type bound_b;
   } cfg_type;

   function automatic logic [31:0] sat36(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > $signed(36'h07FFFFFFF))
         r = 32'h7FFFFFFF;
      else if (v < $signed(36'hF80000000))
         r = 32'h80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/pct_csr.sv
// APB-style register file for clamp enable and box bounds.
// Depends on pct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pct_csr (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [4:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output pct_pkg::cfg_type  cfg
);
   import pct_pkg::*;

   logic        clamp_ff;
   vec3_type    bound_a_ff;
   vec3_type    bound_b_ff;
   logic        wr_en;
   logic [2:0]  idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff   <= 1'b0;
         bound_a_ff <= '0;
         bound_b_ff <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_CLAMP_ENABLE: clamp_ff      <= pwdata[0];
            REG_BOUND_A_X:    bound_a_ff[0] <= pwdata;
            REG_BOUND_A_Y:    bound_a_ff[1] <= pwdata;
            REG_BOUND_A_Z:    bound_a_ff[2] <= pwdata;
            REG_BOUND_B_X:    bound_b_ff[0] <= pwdata;
            REG_BOUND_B_Y:    bound_b_ff[1] <= pwdata;
            REG_BOUND_B_Z:    bound_b_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CLAMP_ENABLE: prdata = {31'd0, clamp_ff};
         REG_BOUND_A_X:    prdata = bound_a_ff[0];
         REG_BOUND_A_Y:    prdata = bound_a_ff[1];
         REG_BOUND_A_Z:    prdata = bound_a_ff[2];
         REG_BOUND_B_X:    prdata = bound_b_ff[0];
         REG_BOUND_B_Y:    prdata = bound_b_ff[1];
         REG_BOUND_B_Z:    prdata = bound_b_ff[2];
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg.clamp_enable = clamp_ff;
   assign cfg.bound_a      = bound_a_ff;
   assign cfg.bound_b      = bound_b_ff;

endmodule

`default_nettype wire

// File: sv/pct_front.sv
// Front pipeline: magnitudes, products, dot sums and numerators n_i*|d.n|.
// Depends on pct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pct_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire pct_pkg::vec3_type start_v,
   input  wire pct_pkg::vec3_type delta_v,
   input  wire pct_pkg::vec3_type normal_v,
   output logic                out_valid,
   output pct_pkg::front_type  out_data
);
   import pct_pkg::*;

   logic [FRONT_LAT-1:0] v_ff;
   ctx_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   vec3_type md1_ff, mn1_ff, mn2_ff, mn3_ff, mn4_ff;
   logic [2:0] sn1_ff, sn2_ff;
   logic [2:0][63:0] sq2_ff, pr2_ff, lp5_ff, hp5_ff;
   logic [63:0] nn3_ff, pos3_ff, neg3_ff, dnm4_ff, den4_ff, den5_ff, den6_ff;
   logic [2:0][95:0] num6_ff;
   logic [63:0] pos_in, neg_in;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[FRONT_LAT-2:0], in_valid};
   end

   // stage 1: magnitudes and sign relations
   always_ff @(posedge clock) begin
      c1_ff.zero  <= 1'b0;
      c1_ff.dneg  <= 1'b0;
      c1_ff.start <= start_v;
      c1_ff.delta <= delta_v;
      for (int i = 0; i < 3; i++) begin
         c1_ff.nneg[i] <= normal_v[i][31];
         md1_ff[i] <= delta_v[i][31] ? (~delta_v[i] + 32'd1) : delta_v[i];
         mn1_ff[i] <= normal_v[i][31] ? (~normal_v[i] + 32'd1) : normal_v[i];
         sn1_ff[i] <= delta_v[i][31] ^ normal_v[i][31];
      end
   end

   // stage 2: squares and per-axis products
   always_ff @(posedge clock) begin
      c2_ff  <= c1_ff;
      mn2_ff <= mn1_ff;
      sn2_ff <= sn1_ff;
      for (int i = 0; i < 3; i++) begin
         sq2_ff[i] <= 64'(mn1_ff[i]) * 64'(mn1_ff[i]);
         pr2_ff[i] <= 64'(md1_ff[i]) * 64'(mn1_ff[i]);
      end
   end

   // split dot product into positive and negative parts
   always_comb begin
      pos_in = '0;
      neg_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (sn2_ff[i]) neg_in = neg_in + pr2_ff[i];
         else           pos_in = pos_in + pr2_ff[i];
      end
   end

   // stage 3: sums
   always_ff @(posedge clock) begin
      c3_ff   <= c2_ff;
      mn3_ff  <= mn2_ff;
      nn3_ff  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      pos3_ff <= pos_in;
      neg3_ff <= neg_in;
   end

   // stage 4: |d.n| and its sign
   always_ff @(posedge clock) begin
      c4_ff.nneg  <= c3_ff.nneg;
      c4_ff.start <= c3_ff.start;
      c4_ff.delta <= c3_ff.delta;
      c4_ff.zero  <= (nn3_ff == 64'd0);
      c4_ff.dneg  <= (neg3_ff > pos3_ff);
      mn4_ff     <= mn3_ff;
      dnm4_ff    <= (neg3_ff > pos3_ff) ? (neg3_ff - pos3_ff) : (pos3_ff - neg3_ff);
      den4_ff    <= nn3_ff;
   end

   // stage 5: 32x32 partial products of n_i * |d.n|
   always_ff @(posedge clock) begin
      c5_ff   <= c4_ff;
      den5_ff <= den4_ff;
      for (int i = 0; i < 3; i++) begin
         lp5_ff[i] <= 64'(mn4_ff[i]) * 64'(dnm4_ff[31:0]);
         hp5_ff[i] <= 64'(mn4_ff[i]) * 64'(dnm4_ff[63:32]);
      end
   end

   // stage 6: assemble 96-bit numerators
   always_ff @(posedge clock) begin
      c6_ff   <= c5_ff;
      den6_ff <= den5_ff;
      for (int i = 0; i < 3; i++)
         num6_ff[i] <= {32'd0, lp5_ff[i]} + {hp5_ff[i], 32'd0};
   end

   assign out_valid    = v_ff[FRONT_LAT-1];
   assign out_data.ctx = c6_ff;
   assign out_data.num = num6_ff;
   assign out_data.den = den6_ff;

endmodule

`default_nettype wire

// File: sv/pct_div.sv
// Pipelined restoring divider, one quotient bit per stage, round half up.
// Depends on pct_pkg; quotient assumed below 2^DIV_STEPS.
`timescale 1ns / 1ps
`default_nettype none

module pct_div (
   input  wire logic        clock,
   input  wire logic [95:0] num,
   input  wire logic [63:0] den,
   output logic [33:0]      quo
);
   import pct_pkg::*;

   logic [63:0] rem_ff [DIV_STEPS];
   logic [63:0] den_ff [DIV_STEPS];
   logic [33:0] q_ff   [DIV_STEPS];
   logic [33:0] low_ff [DIV_STEPS];
   logic [33:0] quo_ff;
   logic [64:0] twice;
   logic        rnd;

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [63:0] rem_src, den_src;
      logic [33:0] q_src, low_src;
      logic [64:0] t_in;
      logic        ge;
      if (j == 0) begin : g_first
         assign rem_src = {2'd0, num[95:34]};
         assign low_src = num[33:0];
         assign q_src   = '0;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign low_src = low_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign den_src = den_ff[j-1];
      end
      assign t_in = {rem_src, low_src[33]};
      assign ge   = (t_in >= {1'b0, den_src});
      always_ff @(posedge clock) begin
         rem_ff[j] <= ge ? 64'(t_in - {1'b0, den_src}) : t_in[63:0];
         q_ff[j]   <= {q_src[32:0], ge};
         low_ff[j] <= {low_src[32:0], 1'b0};
         den_ff[j] <= den_src;
      end
   end

   assign twice = {rem_ff[DIV_STEPS-1], 1'b0};
   assign rnd   = (twice >= {1'b0, den_ff[DIV_STEPS-1]});

   always_ff @(posedge clock) begin
      quo_ff <= q_ff[DIV_STEPS-1] + {33'd0, rnd};
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

// File: sv/pct_back.sv
// Back pipeline: apply correction, clamp to box, saturate, applied delta.
// Depends on pct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pct_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire pct_pkg::ctx_type  ctx,
   input  wire logic [2:0][33:0]  quo,
   input  wire pct_pkg::cfg_type  cfg,
   output logic                   out_valid,
   output logic                   valid_res,
   output pct_pkg::vec3_type      new_pos,
   output pct_pkg::vec3_type      applied
);
   import pct_pkg::*;

   logic [BACK_LAT-1:0] v_ff;
   logic [2:0][35:0] req1_ff;
   vec3_type s1_ff, s2_ff, new2_ff, new3_ff, app3_ff;
   logic z1_ff, z2_ff, ok3_ff;
   logic [2:0][35:0] clamp_in;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[BACK_LAT-2:0], in_valid};
   end

   // b1: start + delta -/+ correction
   always_ff @(posedge clock) begin
      s1_ff <= ctx.start;
      z1_ff <= ctx.zero;
      for (int i = 0; i < 3; i++) begin
         if (ctx.dneg ^ ctx.nneg[i])
            req1_ff[i] <= 36'($signed(ctx.start[i])) + 36'($signed(ctx.delta[i]))
                          + {2'd0, quo[i]};
         else
            req1_ff[i] <= 36'($signed(ctx.start[i])) + 36'($signed(ctx.delta[i]))
                          - {2'd0, quo[i]};
      end
   end

   // swapped bounds accepted: smaller one is the floor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [35:0] lo, hi, a, b;
         a = 36'($signed(cfg.bound_a[i]));
         b = 36'($signed(cfg.bound_b[i]));
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         clamp_in[i] = req1_ff[i];
         if (cfg.clamp_enable) begin
            if ($signed(req1_ff[i]) < lo) clamp_in[i] = lo;
            if ($signed(clamp_in[i]) > hi) clamp_in[i] = hi;
         end
      end
   end

   // b2: clamp and saturate
   always_ff @(posedge clock) begin
      s2_ff <= s1_ff;
      z2_ff <= z1_ff;
      for (int i = 0; i < 3; i++)
         new2_ff[i] <= z1_ff ? s1_ff[i] : sat36(clamp_in[i]);
   end

   // b3: applied delta
   always_ff @(posedge clock) begin
      ok3_ff  <= !z2_ff;
      new3_ff <= new2_ff;
      for (int i = 0; i < 3; i++)
         app3_ff[i] <= z2_ff ? 32'd0 :
                       sat36(36'($signed(new2_ff[i])) - 36'($signed(s2_ff[i])));
   end

   assign out_valid = v_ff[BACK_LAT-1];
   assign valid_res = ok3_ff;
   assign new_pos   = new3_ff;
   assign applied   = app3_ff;

endmodule

`default_nettype wire

// File: sv/plane_constrained_translation_top.sv
// Plane-constrained translation: start to rsp_strobe passes through
// 6 front stages, 34 divider stages, 1 rounding stage and 3 back stages.
// Throughput one word per cycle; busy is low except during reset.
// Set by the one-bit-per-stage quotient pipeline of the three dividers.
// Synchronous active-high reset clears the valid bits and the configuration registers;
// nothing is accepted while reset is high.
`timescale 1ns / 1ps
`default_nettype none
`include "plane_constrained_translation_top_defines.svh"

module plane_constrained_translation_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_start_x,
   input  wire logic [31:0] req_start_y,
   input  wire logic [31:0] req_start_z,
   input  wire logic [31:0] req_delta_x,
   input  wire logic [31:0] req_delta_y,
   input  wire logic [31:0] req_delta_z,
   input  wire logic [31:0] req_normal_x,
   input  wire logic [31:0] req_normal_y,
   input  wire logic [31:0] req_normal_z,
   // result channel, one-cycle strobe, no backpressure
   output logic             rsp_strobe,
   output logic             rsp_valid_res,
   output logic [31:0]      rsp_new_x,
   output logic [31:0]      rsp_new_y,
   output logic [31:0]      rsp_new_z,
   output logic [31:0]      rsp_applied_x,
   output logic [31:0]      rsp_applied_y,
   output logic [31:0]      rsp_applied_z,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import pct_pkg::*;

   cfg_type          cfg;
   logic             accept;
   vec3_type         start_v, delta_v, normal_v;
   logic             front_valid;
   front_type        front_data;
   logic [2:0][33:0] quo;
   // context rides next to the dividers
   ctx_type          ctx_dly_ff [DIV_LAT];
   logic [DIV_LAT-1:0] v_dly_ff;
   vec3_type         new_pos, applied;

   assign busy   = reset;
   assign accept = start && !busy;

   assign start_v  = {req_start_z, req_start_y, req_start_x};
   assign delta_v  = {req_delta_z, req_delta_y, req_delta_x};
   assign normal_v = {req_normal_z, req_normal_y, req_normal_x};

   pct_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   // |n|^2, |d.n| and the per-axis numerators n_i*|d.n|
   pct_front u_front (
      .clock, .reset,
      .in_valid (accept),
      .start_v, .delta_v, .normal_v,
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // correction magnitude round(n_i*|d.n| / |n|^2) per axis
   for (genvar i = 0; i < 3; i++) begin : g_axis
      pct_div u_div (
         .clock,
         .num (front_data.num[i]),
         .den (front_data.den),
         .quo (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) v_dly_ff <= '0;
      else       v_dly_ff <= {v_dly_ff[DIV_LAT-2:0], front_valid};
   end

   always_ff @(posedge clock) begin
      ctx_dly_ff[0] <= front_data.ctx;
      for (int k = 1; k < DIV_LAT; k++)
         ctx_dly_ff[k] <= ctx_dly_ff[k-1];
   end

   pct_back u_back (
      .clock, .reset,
      .in_valid  (v_dly_ff[DIV_LAT-1]),
      .ctx       (ctx_dly_ff[DIV_LAT-1]),
      .quo,
      .cfg,
      .out_valid (rsp_strobe),
      .valid_res (rsp_valid_res),
      .new_pos,
      .applied
   );

   assign rsp_new_x     = new_pos[0];
   assign rsp_new_y     = new_pos[1];
   assign rsp_new_z     = new_pos[2];
   assign rsp_applied_x = applied[0];
   assign rsp_applied_y = applied[1];
   assign rsp_applied_z = applied[2];

   // every strobe traces back to an accepted command
   `PCT_ASSERT_IMP(a_strobe_src, clock, reset, rsp_strobe,
      $past(accept, TOTAL_LAT), "result word without a command")
   // zero normal: nothing applied, x position unchanged
   `PCT_ASSERT_IMP(a_zero_normal, clock, reset, rsp_strobe && !rsp_valid_res,
      applied == '0 && rsp_new_x == $past(req_start_x, TOTAL_LAT),
      "zero normal result altered position")
   // a valid result needs a nonzero normal
   `PCT_ASSERT_IMP(a_valid_normal, clock, reset, rsp_strobe && rsp_valid_res,
      $past(req_normal_x != 0 || req_normal_y != 0 || req_normal_z != 0, TOTAL_LAT),
      "valid flag set for zero normal")

endmodule

`default_nettype wire
